FILE: hdl/hapf_pkg.sv
// Package with the shared types and constants of the packet framer.
package hapf_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgChannelId   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPacketBytes = 2'd1;

  localparam logic [15:0] ChannelIdReset   = 16'd257;
  localparam logic [7:0]  PacketBytesReset = 8'd64;
  localparam logic [7:0]  MinPacketBytes   = 8'd8;
  localparam logic [7:0]  TagByte          = 8'h05;

  // Header lengths in bytes and the position of each header byte.
  localparam logic [2:0] HdrLenNone  = 3'd0;
  localparam logic [2:0] HdrLenNext  = 3'd5;
  localparam logic [2:0] HdrLenFirst = 3'd7;

  localparam logic [2:0] HdrChanHi = 3'd0;
  localparam logic [2:0] HdrChanLo = 3'd1;
  localparam logic [2:0] HdrTag    = 3'd2;
  localparam logic [2:0] HdrSeqHi  = 3'd3;
  localparam logic [2:0] HdrSeqLo  = 3'd4;
  localparam logic [2:0] HdrLenHi  = 3'd5;
  localparam logic [2:0] HdrLenLo  = 3'd6;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] command_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic       end_of_command;
    logic       last_of_run;
  } out_item_t;

  // Everything the serializer needs to emit the results of one input byte.
  typedef struct packed {
    logic [15:0] channel;
    logic [15:0] seq;
    logic [15:0] length;
    logic [2:0]  hdr_len;
    logic [7:0]  data;
    logic        eop;
    logic        eoc;
  } run_t;

endpackage

FILE: hdl/hid_apdu_packet_framer.sv
// Command byte packet framer with header insertion, top level.
// Each accepted command byte, unless it opens a zero-length command and is
// dropped, yields its data byte on the output, preceded by a packet header
// when it opens a packet: 5 header bytes, or 7 on the first packet of a
// command, which also carries the command length. The serializer holds the
// results of one input byte and moves one result per cycle, while the output
// is not stalled, into the output register, so a byte with no header is taken
// every cycle; the next byte is taken in the cycle the last result is registered.
// Configuration writes are only expected while no transaction is in flight.
module hid_apdu_packet_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hapf_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hapf_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [hapf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hapf_pkg::CfgDataW-1:0] cfg_data_i
);
  import hapf_pkg::*;

  logic run_load;
  run_t run;
  logic run_ready;

  hapf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .run_load_o  (run_load),
    .run_o       (run),
    .run_ready_i (run_ready)
  );

  hapf_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_load_i  (run_load),
    .run_i       (run),
    .run_ready_o (run_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/hapf_core.sv
// Framing state, configuration registers and per-byte run computation.
module hapf_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hapf_pkg::in_item_t           in_data_i,
  input  logic                         cfg_we_i,
  input  logic [hapf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hapf_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         run_load_o,
  output hapf_pkg::run_t               run_o,
  input  logic                         run_ready_i
);
  import hapf_pkg::*;

  logic [15:0] channel_q;
  logic [7:0]  pkt_bytes_q;
  logic        in_cmd_q, in_cmd_d;
  logic [15:0] left_q, left_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  fill_q, fill_d;

  logic        accept;
  logic        start;
  logic        drop;
  logic [7:0]  size;
  logic [15:0] left_cur;
  logic [15:0] left_dec;
  logic [15:0] seq_cur;
  logic [7:0]  fill_cur;
  logic [2:0]  hdr_len;
  logic [7:0]  fill_base;
  logic [7:0]  fill_inc;
  logic        eoc;
  logic        eop;

  assign in_ready_o = run_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    size      = (pkt_bytes_q < MinPacketBytes) ? MinPacketBytes : pkt_bytes_q;
    start     = !in_cmd_q;
    drop      = start && (in_data_i.command_length == 16'd0);
    left_cur  = start ? in_data_i.command_length : left_q;
    seq_cur   = start ? 16'd0 : seq_q;
    fill_cur  = start ? 8'd0 : fill_q;
    if (fill_cur != 8'd0) begin
      hdr_len = HdrLenNone;
    end else if (seq_cur == 16'd0) begin
      hdr_len = HdrLenFirst;
    end else begin
      hdr_len = HdrLenNext;
    end
    fill_base = (fill_cur == 8'd0) ? {5'd0, hdr_len} : fill_cur;
    fill_inc  = fill_base + 8'd1;
    left_dec  = left_cur - 16'd1;
    eoc       = (left_dec == 16'd0);
    eop       = eoc || (fill_inc >= size);

    in_cmd_d = in_cmd_q;
    left_d   = left_q;
    seq_d    = seq_q;
    fill_d   = fill_q;
    if (accept && !drop) begin
      left_d = left_dec;
      if (eoc) begin
        in_cmd_d = 1'b0;
        seq_d    = 16'd0;
        fill_d   = 8'd0;
      end else if (eop) begin
        in_cmd_d = 1'b1;
        seq_d    = seq_cur + 16'd1;
        fill_d   = 8'd0;
      end else begin
        in_cmd_d = 1'b1;
        seq_d    = seq_cur;
        fill_d   = fill_inc;
      end
    end
  end

  assign run_load_o      = accept && !drop;
  assign run_o.channel   = channel_q;
  assign run_o.seq       = seq_cur;
  assign run_o.length    = left_cur;
  assign run_o.hdr_len   = hdr_len;
  assign run_o.data      = in_data_i.data_byte;
  assign run_o.eop       = eop;
  assign run_o.eoc       = eoc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cmd_q <= 1'b0;
      left_q   <= 16'd0;
      seq_q    <= 16'd0;
      fill_q   <= 8'd0;
    end else begin
      in_cmd_q <= in_cmd_d;
      left_q   <= left_d;
      seq_q    <= seq_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q   <= ChannelIdReset;
      pkt_bytes_q <= PacketBytesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgChannelId:   channel_q   <= cfg_data_i;
        CfgPacketBytes: pkt_bytes_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/hapf_serializer.sv
// Holds one run of results and emits it a byte per cycle, unless stalled, into the output register.
module hapf_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                run_load_i,
  input  hapf_pkg::run_t      run_i,
  output logic                run_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hapf_pkg::out_item_t out_data_o
);
  import hapf_pkg::*;

  logic      run_valid_q;
  run_t      run_q;
  logic [2:0] idx_q;
  logic      out_valid_q;
  out_item_t out_q;

  logic      out_adv;
  logic      move;
  logic      is_last;
  out_item_t cur;

  assign out_adv     = !out_valid_q || out_ready_i;
  assign move        = run_valid_q && out_adv;
  assign is_last     = (idx_q == run_q.hdr_len);
  assign run_ready_o = !run_valid_q || (move && is_last);

  always_comb begin
    cur.end_of_packet  = 1'b0;
    cur.end_of_command = 1'b0;
    cur.last_of_run    = 1'b0;
    if (is_last) begin
      cur.out_byte       = run_q.data;
      cur.end_of_packet  = run_q.eop;
      cur.end_of_command = run_q.eoc;
      cur.last_of_run    = 1'b1;
    end else begin
      unique case (idx_q)
        HdrChanHi: cur.out_byte = run_q.channel[15:8];
        HdrChanLo: cur.out_byte = run_q.channel[7:0];
        HdrTag:    cur.out_byte = TagByte;
        HdrSeqHi:  cur.out_byte = run_q.seq[15:8];
        HdrSeqLo:  cur.out_byte = run_q.seq[7:0];
        HdrLenHi:  cur.out_byte = run_q.length[15:8];
        HdrLenLo:  cur.out_byte = run_q.length[7:0];
        default:   cur.out_byte = run_q.data;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // A new run may enter in the same cycle that the old one drains.
      if (run_load_i) begin
        run_valid_q <= 1'b1;
        idx_q       <= 3'd0;
      end else if (move) begin
        if (is_last) begin
          run_valid_q <= 1'b0;
          idx_q       <= 3'd0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= cur;
    end
    if (run_load_i) begin
      run_q <= run_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/hapf_checker.sv
// Port-level checks for the packet framer and the bind that attaches them.
module hapf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hapf_pkg::out_item_t out_data_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // The end of a command always closes the packet.
  a_eoc_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_command |-> out_data_o.end_of_packet)
    else $error("command ended without closing its packet");

  // Packets close only on a data byte, which ends its run.
  a_eop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_packet |-> out_data_o.last_of_run)
    else $error("packet closed on a header byte");

  // Once a run has started, its remaining results follow without a gap.
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("gap inside a run of results");

endmodule

bind hid_apdu_packet_framer hapf_checker u_hapf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
